// ===== rtl/core/cfba_pkg.sv =====
// Package for the chunked free-list block allocator.
// Holds sizing constants, status codes and the sequencer state type.
// No dependencies.
`default_nettype none
package cfba_pkg;
	localparam int MAX_CHUNKS  = 16;
	localparam int BLOCK_LIMIT = 64;
	localparam int SLOT_W      = $clog2(MAX_CHUNKS);
	localparam int BLK_W       = $clog2(BLOCK_LIMIT);
	localparam int LIVE_W      = $clog2(MAX_CHUNKS + 1);
	localparam int CNT_W       = 7;
	localparam int LINK_W      = 7;
	localparam int ADDR_W      = SLOT_W + BLK_W;
	localparam int OFF_W       = 18;
	localparam int PROD_W      = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_CHUNK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE       = 1'd1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_BAD       = 2'd2
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_A_CUR, S_A_SCAN, S_A_NEW, S_A_INIT, S_POP_RD, S_POP_WB, S_MUL,
		S_F_CHK, S_F_TAIL, S_F_TAIL2, S_F_SWAP, S_DONE
	} fsm_t;
endpackage
`default_nettype wire

// ===== rtl/core/cfba_ifs.sv =====
// Handshake interfaces for the allocator: request, result and register write.
// Depends on cfba_pkg.
`default_nettype none
interface cfba_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [cfba_pkg::SLOT_W-1:0] chunk_slot;
	logic [cfba_pkg::BLK_W-1:0] block_index;
	modport source (output valid, op, chunk_slot, block_index, input ready);
	modport sink (input valid, op, chunk_slot, block_index, output ready);
endinterface

interface cfba_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [cfba_pkg::SLOT_W-1:0] alloc_slot;
	logic [cfba_pkg::BLK_W-1:0] alloc_block;
	logic [cfba_pkg::OFF_W-1:0] byte_offset;
	modport source (output valid, status, alloc_slot, alloc_block, byte_offset, input ready);
	modport sink (input valid, status, alloc_slot, alloc_block, byte_offset, output ready);
endinterface

interface cfba_cfg_if;
	logic valid;
	logic ready;
	logic [cfba_pkg::CFG_IDX_W-1:0] index;
	logic [cfba_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/chunked_free_list_block_allocator_top.sv =====
// Chunked free-list block allocator: one result word for each request word.
// Allocate from the cached chunk: the request passes S_A_CUR, S_POP_RD, S_POP_WB and S_MUL
// before S_DONE. A miss scans the order in S_A_SCAN, one order position at a time; creating
// a chunk adds S_A_NEW, then S_A_INIT writes the link of each block in the link RAM. Free passes
// S_F_CHK, then S_F_TAIL, S_F_TAIL2 and S_F_SWAP as needed. One request is in work at a time, and a
// result word waiting in the output register holds the sequencer. Reset clears control state only.
`default_nettype none
module chunked_free_list_block_allocator_top (
	input wire logic clk,
	input wire logic arst_n,
	cfba_req_if.sink in_ch,
	cfba_rsp_if.source out_ch,
	cfba_cfg_if.sink cfg
);
	localparam int NC = cfba_pkg::MAX_CHUNKS;
	localparam int SW = cfba_pkg::SLOT_W;
	localparam int BW = cfba_pkg::BLK_W;
	localparam int LW = cfba_pkg::LIVE_W;
	localparam int CW = cfba_pkg::CNT_W;

	// Configuration registers; blocks_per_chunk is clamped into 1..BLOCK_LIMIT.
	logic [CW-1:0] bpc_q;
	logic [7:0]    bsize_q;
	logic [CW-1:0] n_eff;

	// Per-chunk tables, indexed by chunk slot or by order position.
	logic          slot_live_q [NC];
	logic [CW-1:0] free_head_q [NC];
	logic [CW-1:0] free_count_q [NC];
	logic [SW-1:0] o2s_q [NC];
	logic [SW-1:0] s2o_q [NC];

	logic [LW-1:0] live_q;
	logic [SW-1:0] cur_q;
	logic          cur_ok_q;
	logic [SW-1:0] fcur_q;

	// Request and work registers.
	cfba_pkg::fsm_t state_q, state_d;
	logic [SW-1:0] slot_q;
	logic [BW-1:0] blk_q;
	logic [LW-1:0] idx_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] b_q;
	logic [SW-1:0] t_q;
	logic [cfba_pkg::PROD_W-1:0] prod_s1;

	// Pending result and output register.
	cfba_pkg::status_t res_status_q;
	logic [SW-1:0] res_slot_q;
	logic [BW-1:0] res_block_q;
	logic [cfba_pkg::OFF_W-1:0] res_off_q;
	logic out_valid_q;

	// Link RAM interface.
	logic ram_we;
	logic [cfba_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [cfba_pkg::LINK_W-1:0] ram_wdata, ram_rdata;

	// Derived conditions.
	logic [LW-1:0] last;
	logic [SW-1:0] cur_slot, scan_slot, new_slot;
	logic cur_hit, scan_hit, have_free_slot, free_bad, free_partial, is_last, tail_full;
	logic [CW-1:0] cnt_inc;
	logic [LW-1:0] live_rel;
	logic do_swap;
	logic res_load;
	logic [cfba_pkg::PROD_W+7:0] off_full;

	always_comb begin
		if (bpc_q == '0) begin
			n_eff = CW'(1);
		end else if (bpc_q > CW'(cfba_pkg::BLOCK_LIMIT)) begin
			n_eff = CW'(cfba_pkg::BLOCK_LIMIT);
		end else begin
			n_eff = bpc_q;
		end
	end

	// Lowest slot not in use for a new chunk.
	always_comb begin
		new_slot = '0;
		have_free_slot = 1'b0;
		for (int s = NC - 1; s >= 0; s--) begin
			if (!slot_live_q[s]) begin
				new_slot = SW'(s);
				have_free_slot = 1'b1;
			end
		end
	end

	assign last         = live_q - LW'(1);
	assign cur_slot     = o2s_q[cur_q];
	assign cur_hit      = cur_ok_q && ({1'b0, cur_q} < live_q) && (free_count_q[cur_slot] != '0);
	assign scan_slot    = o2s_q[idx_q[SW-1:0]];
	assign scan_hit     = free_count_q[scan_slot] != '0;
	assign free_bad     = !slot_live_q[slot_q] || ({1'b0, blk_q} >= n_eff) || (live_q == '0);
	assign cnt_inc      = free_count_q[slot_q] + CW'(1);
	assign free_partial = cnt_inc != n_eff;
	assign is_last      = {1'b0, fcur_q} == last;
	assign tail_full    = free_count_q[t_q] == n_eff;
	assign live_rel     = live_q - LW'(tail_full);
	// A chunk that already sits at the back of the order needs no swap.
	assign do_swap      = (live_rel > LW'(1)) && ({1'b0, fcur_q} < live_rel - LW'(1));
	assign off_full     = prod_s1 * bsize_q;
	assign res_load     = (state_q == cfba_pkg::S_DONE) && (!out_valid_q || out_ch.ready);

	// Link RAM: written while a new chunk is threaded and on every good free,
	// read once for each pop at the current head.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {slot_q, j_q[BW-1:0]};
		ram_wdata = j_q + CW'(1);
		if (state_q == cfba_pkg::S_A_INIT) begin
			ram_we = 1'b1;
		end else if (state_q == cfba_pkg::S_F_CHK && !free_bad) begin
			ram_we    = 1'b1;
			ram_waddr = {slot_q, blk_q};
			ram_wdata = free_head_q[slot_q];
		end
	end
	assign ram_raddr = {slot_q, free_head_q[slot_q][BW-1:0]};

	cfba_ram #(
		.WIDTH(cfba_pkg::LINK_W),
		.DEPTH(NC * cfba_pkg::BLOCK_LIMIT)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cfba_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					state_d = (in_ch.op == cfba_pkg::OP_FREE) ? cfba_pkg::S_F_CHK
						: cfba_pkg::S_A_CUR;
				end
			end
			cfba_pkg::S_A_CUR:  state_d = cur_hit ? cfba_pkg::S_POP_RD : cfba_pkg::S_A_SCAN;
			cfba_pkg::S_A_SCAN: begin
				if (idx_q >= live_q) begin
					state_d = cfba_pkg::S_A_NEW;
				end else if (scan_hit) begin
					state_d = cfba_pkg::S_POP_RD;
				end
			end
			cfba_pkg::S_A_NEW: begin
				state_d = (live_q >= LW'(NC) || !have_free_slot) ? cfba_pkg::S_DONE
					: cfba_pkg::S_A_INIT;
			end
			cfba_pkg::S_A_INIT: begin
				if (j_q == n_eff - CW'(1)) begin
					state_d = cfba_pkg::S_POP_RD;
				end
			end
			cfba_pkg::S_POP_RD: state_d = cfba_pkg::S_POP_WB;
			cfba_pkg::S_POP_WB: state_d = cfba_pkg::S_MUL;
			cfba_pkg::S_MUL:    state_d = cfba_pkg::S_DONE;
			cfba_pkg::S_F_CHK:  begin
				state_d = (free_bad || free_partial) ? cfba_pkg::S_DONE : cfba_pkg::S_F_TAIL;
			end
			cfba_pkg::S_F_TAIL: state_d = cfba_pkg::S_F_TAIL2;
			cfba_pkg::S_F_TAIL2: begin
				state_d = (!is_last && do_swap) ? cfba_pkg::S_F_SWAP : cfba_pkg::S_DONE;
			end
			cfba_pkg::S_F_SWAP: state_d = cfba_pkg::S_DONE;
			cfba_pkg::S_DONE: begin
				if (res_load) begin
					state_d = cfba_pkg::S_IDLE;
				end
			end
			default: state_d = cfba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: counts, cursors, live bits, configuration, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q       <= CW'(64);
			bsize_q     <= 8'd8;
			live_q      <= '0;
			cur_q       <= '0;
			cur_ok_q    <= 1'b0;
			fcur_q      <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < NC; s++) begin
				slot_live_q[s] <= 1'b0;
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					cfba_pkg::REG_BLOCKS_PER_CHUNK: bpc_q <= cfg.data[CW-1:0];
					cfba_pkg::REG_BLOCK_SIZE:       bsize_q <= cfg.data;
					default: ;
				endcase
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				cfba_pkg::S_A_SCAN: begin
					if (idx_q < live_q && scan_hit) begin
						cur_q    <= idx_q[SW-1:0];
						cur_ok_q <= 1'b1;
					end
				end
				cfba_pkg::S_A_INIT: begin
					if (j_q == n_eff - CW'(1)) begin
						slot_live_q[slot_q] <= 1'b1;
						live_q   <= live_q + LW'(1);
						cur_q    <= live_q[SW-1:0];
						fcur_q   <= live_q[SW-1:0];
						cur_ok_q <= 1'b1;
					end
				end
				cfba_pkg::S_F_CHK: begin
					if (!free_bad) begin
						fcur_q <= s2o_q[slot_q];
					end
				end
				cfba_pkg::S_F_TAIL2: begin
					if (is_last) begin
						// The freed chunk is last: drop it if the one before is also empty.
						if (live_q > LW'(1) && tail_full) begin
							slot_live_q[slot_q] <= 1'b0;
							live_q   <= last;
							cur_q    <= '0;
							fcur_q   <= '0;
							cur_ok_q <= 1'b1;
						end
					end else begin
						if (tail_full) begin
							slot_live_q[t_q] <= 1'b0;
						end
						live_q   <= live_rel;
						cur_q    <= SW'(live_rel - LW'(1));
						// The swap still needs the freed chunk's order position.
						if (!do_swap) begin
							fcur_q <= SW'(live_rel - LW'(1));
						end
						cur_ok_q <= 1'b1;
					end
				end
				cfba_pkg::S_F_SWAP: begin
					fcur_q <= last[SW-1:0];
				end
				default: ;
			endcase
		end
	end

	// Chunk tables and work registers.
	always_ff @(posedge clk) begin
		case (state_q)
			cfba_pkg::S_IDLE: begin
				slot_q <= in_ch.chunk_slot;
				blk_q  <= in_ch.block_index;
				idx_q  <= '0;
				j_q    <= '0;
			end
			cfba_pkg::S_A_CUR: begin
				slot_q <= cur_slot;
			end
			cfba_pkg::S_A_SCAN: begin
				slot_q <= scan_slot;
				idx_q  <= idx_q + LW'(1);
			end
			cfba_pkg::S_A_NEW: begin
				slot_q       <= new_slot;
				res_status_q <= cfba_pkg::ST_POOL_FULL;
				res_slot_q   <= '0;
				res_block_q  <= '0;
				res_off_q    <= '0;
			end
			cfba_pkg::S_A_INIT: begin
				j_q <= j_q + CW'(1);
				if (j_q == n_eff - CW'(1)) begin
					free_head_q[slot_q]  <= '0;
					free_count_q[slot_q] <= n_eff;
					o2s_q[live_q[SW-1:0]] <= slot_q;
					s2o_q[slot_q]         <= live_q[SW-1:0];
				end
			end
			cfba_pkg::S_POP_RD: begin
				b_q <= free_head_q[slot_q];
			end
			cfba_pkg::S_POP_WB: begin
				// A head past the block limit only follows a double free; its link is zero.
				free_head_q[slot_q]  <= b_q[BW] ? '0 : ram_rdata;
				free_count_q[slot_q] <= free_count_q[slot_q] - CW'(1);
				prod_s1 <= cfba_pkg::PROD_W'(slot_q) * cfba_pkg::PROD_W'(n_eff)
					+ cfba_pkg::PROD_W'(b_q);
			end
			cfba_pkg::S_MUL: begin
				res_status_q <= cfba_pkg::ST_OK;
				res_slot_q   <= slot_q;
				res_block_q  <= b_q[BW-1:0];
				res_off_q    <= off_full[cfba_pkg::OFF_W-1:0];
			end
			cfba_pkg::S_F_CHK: begin
				res_status_q <= free_bad ? cfba_pkg::ST_BAD : cfba_pkg::ST_OK;
				res_slot_q   <= '0;
				res_block_q  <= '0;
				res_off_q    <= '0;
				if (!free_bad) begin
					free_head_q[slot_q]  <= {1'b0, blk_q};
					free_count_q[slot_q] <= cnt_inc;
				end
			end
			cfba_pkg::S_F_TAIL: begin
				t_q <= o2s_q[is_last ? SW'(last - LW'(1)) : last[SW-1:0]];
			end
			cfba_pkg::S_F_SWAP: begin
				// Swap the emptied chunk with the back of the order.
				o2s_q[fcur_q]             <= o2s_q[last[SW-1:0]];
				o2s_q[last[SW-1:0]]       <= slot_q;
				s2o_q[o2s_q[last[SW-1:0]]] <= fcur_q;
				s2o_q[slot_q]             <= last[SW-1:0];
			end
			default: ;
		endcase
	end

	// Output register holds a finished word while the next request is taken.
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_ch.status      <= res_status_q;
			out_ch.alloc_slot  <= res_slot_q;
			out_ch.alloc_block <= res_block_q;
			out_ch.byte_offset <= res_off_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign in_ch.ready  = state_q == cfba_pkg::S_IDLE;
	assign cfg.ready    = 1'b1;
endmodule
`default_nettype wire

// ===== rtl/core/cfba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module cfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
